/* rtl/core/asdrc_pkg.sv */
// ----------------------------------------------------------------------------
// asdrc_pkg
// Shared widths, pipeline payload types and helpers for the stick
// dead-zone and radial clamp pipeline.
// ----------------------------------------------------------------------------
package asdrc_pkg;

    localparam int FRAC_BITS   = 8;

    localparam int RAW_W       = 8;
    localparam int AXIS_W      = 8;
    localparam int MAG_W       = 8;
    localparam int DZ_W        = 7;
    localparam int OFS_W       = 7;
    localparam int MAXR_W      = 8;
    localparam int CFG_W       = 8;

    localparam int SUM_W       = 2 * MAG_W;
    localparam int RAD_W       = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

    localparam int MAXF_W      = MAXR_W + FRAC_BITS;
    localparam int NUM_W       = MAG_W + FRAC_BITS + MAXF_W;
    localparam int QUO_W       = MAG_W - 1 + FRAC_BITS;
    localparam int DREM_W      = NUM_W - QUO_W;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int OUT_AXIS_W  = 17;
    localparam int OUT_MAG_W   = 16;
    localparam int RES_W       = 2 * OUT_AXIS_W + OUT_MAG_W;
    localparam int IN_TDATA_W  = ((2 * RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_DEAD_ZONE     = 2'd0,
        CFG_CENTER_OFFSET = 2'd1,
        CFG_MAX_MAG       = 2'd2,
        CFG_SPARE         = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DZ_W-1:0]   dead_zone;
        logic [OFS_W-1:0]  center_offset;
        logic [MAXR_W-1:0] max_mag;
    } t_cfg;

    typedef struct packed {
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] ax;
    } t_vec;

    typedef struct packed {
        t_vec             vec;
        logic [SUM_W-1:0] sum;
    } t_sum_item;

    typedef struct packed {
        t_vec              vec;
        logic [ROOT_W-1:0] root;
    } t_root_item;

    typedef struct packed {
        logic        [OUT_MAG_W-1:0]  mag;
        logic signed [OUT_AXIS_W-1:0] y;
        logic signed [OUT_AXIS_W-1:0] x;
    } t_result;

    function automatic logic [MAG_W-1:0] axis_mag(logic signed [AXIS_W-1:0] a);
        return a[AXIS_W-1] ? MAG_W'(-a) : MAG_W'(a);
    endfunction

endpackage

/* rtl/core/asdrc_cond.sv */
// ----------------------------------------------------------------------------
// asdrc_cond
// Dead zone and centre pull per axis, then sum of squares. Two stages.
// ----------------------------------------------------------------------------
module asdrc_cond (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  asdrc_pkg::t_cfg                     i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [asdrc_pkg::RAW_W-1:0]  i_raw_x,
    input  logic signed [asdrc_pkg::RAW_W-1:0]  i_raw_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output asdrc_pkg::t_sum_item                o_item
);
    import asdrc_pkg::*;

    logic [1:0] r_vld;
    logic [1:0] w_en;
    t_vec       r_vec;
    t_vec       n_vec;
    t_sum_item  r_item;
    t_sum_item  n_item;
    logic [SUM_W-1:0] w_sq_x;
    logic [SUM_W-1:0] w_sq_y;

    function automatic logic signed [AXIS_W-1:0] cond_axis(logic signed [RAW_W-1:0] raw,
                                                           t_cfg cfg);
        logic [MAG_W-1:0]         mag;
        logic signed [AXIS_W-1:0] ofs;
        mag = axis_mag(raw);
        ofs = AXIS_W'(cfg.center_offset);
        if (mag < MAG_W'(cfg.dead_zone)) begin
            return '0;
        end else if (raw[RAW_W-1]) begin
            return raw + ofs;
        end else begin
            return raw - ofs;
        end
    endfunction

    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[1];
    assign o_item  = r_item;

    always_comb begin
        n_vec.ax = cond_axis(i_raw_x, i_cfg);
        n_vec.ay = cond_axis(i_raw_y, i_cfg);
    end

    assign w_sq_x = SUM_W'(axis_mag(r_vec.ax)) * SUM_W'(axis_mag(r_vec.ax));
    assign w_sq_y = SUM_W'(axis_mag(r_vec.ay)) * SUM_W'(axis_mag(r_vec.ay));

    always_comb begin
        n_item.vec = r_vec;
        n_item.sum = w_sq_x + w_sq_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_vec <= n_vec;
        end
        if (w_en[1]) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/core/asdrc_sqrt.sv */
// ----------------------------------------------------------------------------
// asdrc_sqrt
// Pipelined digit-by-digit square root of the sum of squares, scaled by
// the fraction bits. Two root bits per stage, truncated result.
// ----------------------------------------------------------------------------
module asdrc_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  asdrc_pkg::t_sum_item  i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output asdrc_pkg::t_root_item o_item
);
    import asdrc_pkg::*;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_slane;

    typedef struct packed {
        t_slane lane;
        t_vec   vec;
    } t_sstage;

    logic [SQRT_STAGES-1:0] r_vld;
    logic [SQRT_STAGES-1:0] w_en;
    logic [SQRT_STAGES-1:0] w_vld_in;
    t_sstage                r_st [SQRT_STAGES];

    function automatic t_slane sqrt_steps(t_slane lane_in, int base);
        t_slane            lane;
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;
        lane   = lane_in;
        rem_sh = '0;
        trial  = '0;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            if (base + j < ROOT_W) begin
                rem_sh   = {lane.rem[SREM_W-3:0], lane.rad[RAD_W-1 -: 2]};
                lane.rad = {lane.rad[RAD_W-3:0], 2'b00};
                trial    = {lane.root, 2'b01};
                if (rem_sh >= trial) begin
                    lane.rem  = rem_sh - trial;
                    lane.root = {lane.root[ROOT_W-2:0], 1'b1};
                end else begin
                    lane.rem  = rem_sh;
                    lane.root = {lane.root[ROOT_W-2:0], 1'b0};
                end
            end
        end
        return lane;
    endfunction

    always_comb begin
        w_en[SQRT_STAGES-1] = !r_vld[SQRT_STAGES-1] || i_ready;
        for (int k = SQRT_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign w_vld_in    = {r_vld[SQRT_STAGES-2:0], i_valid};
    assign o_ready     = w_en[0];
    assign o_valid     = r_vld[SQRT_STAGES-1];
    assign o_item.vec  = r_st[SQRT_STAGES-1].vec;
    assign o_item.root = r_st[SQRT_STAGES-1].lane.root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        t_sstage w_in;
        t_sstage n_st;

        if (k == 0) begin : g_head
            always_comb begin
                w_in.vec       = i_item.vec;
                w_in.lane.rem  = '0;
                w_in.lane.root = '0;
                w_in.lane.rad  = {i_item.sum, {(2 * FRAC_BITS){1'b0}}};
            end
        end else begin : g_body
            assign w_in = r_st[k - 1];
        end

        always_comb begin
            n_st.vec  = w_in.vec;
            n_st.lane = sqrt_steps(w_in.lane, k * SQRT_STEPS);
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

endmodule

/* rtl/core/asdrc_scale.sv */
// ----------------------------------------------------------------------------
// asdrc_scale
// Radial clamp: compare length with the limit, form max * |axis|, divide
// both axes by the length in a restoring pipeline, then select and sign.
// ----------------------------------------------------------------------------
module asdrc_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  asdrc_pkg::t_cfg       i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  asdrc_pkg::t_root_item i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output asdrc_pkg::t_result    o_res
);
    import asdrc_pkg::*;

    localparam int NS = DIV_STAGES + 2;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [QUO_W-1:0]  low;
    } t_dlane;

    typedef struct packed {
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
        logic [ROOT_W-1:0] len;
        logic              clamp;
        t_vec              vec;
    } t_pre;

    typedef struct packed {
        t_dlane            x;
        t_dlane            y;
        logic [ROOT_W-1:0] len;
        logic              clamp;
        t_vec              vec;
    } t_dstage;

    logic [NS-1:0]     r_vld;
    logic [NS-1:0]     w_en;
    logic [NS-1:0]     w_vld_in;
    logic [MAXF_W-1:0] w_maxf;
    t_pre              r_pre;
    t_pre              n_pre;
    t_dstage           r_dst [DIV_STAGES];
    t_result           r_res;
    t_result           n_res;

    function automatic t_dlane div_steps(t_dlane lane_in, logic [ROOT_W-1:0] len, int base);
        t_dlane            lane;
        logic [DREM_W-1:0] rem_sh;
        lane   = lane_in;
        rem_sh = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (base + j < QUO_W) begin
                rem_sh   = {lane.rem[DREM_W-2:0], lane.low[QUO_W-1]};
                lane.low = {lane.low[QUO_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, len}) begin
                    lane.rem = rem_sh - {1'b0, len};
                    lane.quo = {lane.quo[QUO_W-2:0], 1'b1};
                end else begin
                    lane.rem = rem_sh;
                    lane.quo = {lane.quo[QUO_W-2:0], 1'b0};
                end
            end
        end
        return lane;
    endfunction

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign w_vld_in = {r_vld[NS-2:0], i_valid};
    assign o_ready  = w_en[0];
    assign o_valid  = r_vld[NS-1];
    assign o_res    = r_res;
    assign w_maxf   = {i_cfg.max_mag, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    // numerators |axis| * 2^f * max * 2^f
    always_comb begin
        n_pre.num_x = NUM_W'({axis_mag(i_item.vec.ax), {FRAC_BITS{1'b0}}}) * NUM_W'(w_maxf);
        n_pre.num_y = NUM_W'({axis_mag(i_item.vec.ay), {FRAC_BITS{1'b0}}}) * NUM_W'(w_maxf);
        n_pre.len   = i_item.root;
        n_pre.clamp = i_item.root > w_maxf;
        n_pre.vec   = i_item.vec;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pre <= n_pre;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        t_dstage w_in;
        t_dstage n_st;

        if (k == 0) begin : g_head
            always_comb begin
                w_in.x.rem = r_pre.num_x[NUM_W-1:QUO_W];
                w_in.x.quo = '0;
                w_in.x.low = r_pre.num_x[QUO_W-1:0];
                w_in.y.rem = r_pre.num_y[NUM_W-1:QUO_W];
                w_in.y.quo = '0;
                w_in.y.low = r_pre.num_y[QUO_W-1:0];
                w_in.len   = r_pre.len;
                w_in.clamp = r_pre.clamp;
                w_in.vec   = r_pre.vec;
            end
        end else begin : g_body
            assign w_in = r_dst[k - 1];
        end

        always_comb begin
            n_st       = w_in;
            n_st.x     = div_steps(w_in.x, w_in.len, k * DIV_STEPS);
            n_st.y     = div_steps(w_in.y, w_in.len, k * DIV_STEPS);
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k + 1]) begin
                r_dst[k] <= n_st;
            end
        end
    end

    always_comb begin
        t_dstage last;
        last = r_dst[DIV_STAGES-1];
        if (last.clamp) begin
            n_res.x   = last.vec.ax[AXIS_W-1] ? -OUT_AXIS_W'(last.x.quo)
                                              : OUT_AXIS_W'(last.x.quo);
            n_res.y   = last.vec.ay[AXIS_W-1] ? -OUT_AXIS_W'(last.y.quo)
                                              : OUT_AXIS_W'(last.y.quo);
            n_res.mag = OUT_MAG_W'(w_maxf);
        end else begin
            n_res.x   = {{(OUT_AXIS_W - AXIS_W - FRAC_BITS){last.vec.ax[AXIS_W-1]}},
                         last.vec.ax, {FRAC_BITS{1'b0}}};
            n_res.y   = {{(OUT_AXIS_W - AXIS_W - FRAC_BITS){last.vec.ay[AXIS_W-1]}},
                         last.vec.ay, {FRAC_BITS{1'b0}}};
            n_res.mag = OUT_MAG_W'(last.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_res <= n_res;
        end
    end

endmodule

/* rtl/core/analog_stick_deadzone_radial_clamp.sv */
// ----------------------------------------------------------------------------
// analog_stick_deadzone_radial_clamp
// Stick conditioning: per-axis dead zone and centre pull, vector length,
// radial clamp to a configurable maximum, 8 fraction bit output.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not held and
// no stage is stalled, and returns one result per transaction, in order: the
// axis conditioning and sum of squares, then the square root (two root bits
// per stage), then the clamp compare, multiply, 15-bit restoring divide (two
// quotient bits per stage) and output register. Every stage holds its own
// valid bit and moves up into an empty slot, so input is still taken while a
// finished result waits. Configuration writes take effect at once and are
// meant for an empty pipeline.
module analog_stick_deadzone_radial_clamp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // raw_x, raw_y
    input  logic [asdrc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // stick_x, stick_y, stick_mag, zero padding
    output logic [asdrc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [asdrc_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import asdrc_pkg::*;

    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST     = DZ_W'(8);
    localparam logic [OFS_W-1:0]  CENTER_OFFSET_RST = OFS_W'(6);
    localparam logic [MAXR_W-1:0] MAX_MAG_RST       = MAXR_W'(64);

    t_cfg       r_cfg;
    logic       w_c_valid;
    logic       w_c_ready;
    t_sum_item  w_c_item;
    logic       w_r_valid;
    logic       w_r_ready;
    t_root_item w_r_item;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone     <= DEAD_ZONE_RST;
            r_cfg.center_offset <= CENTER_OFFSET_RST;
            r_cfg.max_mag       <= MAX_MAG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_DEAD_ZONE: begin
                    r_cfg.dead_zone <= i_cfg_wdata[DZ_W-1:0];
                end
                CFG_CENTER_OFFSET: begin
                    r_cfg.center_offset <= i_cfg_wdata[OFS_W-1:0];
                end
                CFG_MAX_MAG: begin
                    r_cfg.max_mag <= i_cfg_wdata[MAXR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    asdrc_cond u_cond (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_raw_x (i_s_axis_tdata[RAW_W-1:0]),
        .i_raw_y (i_s_axis_tdata[2*RAW_W-1:RAW_W]),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_item  (w_c_item)
    );

    asdrc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_item  (w_c_item),
        .o_valid (w_r_valid),
        .i_ready (w_r_ready),
        .o_item  (w_r_item)
    );

    asdrc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_r_valid),
        .o_ready (w_r_ready),
        .i_item  (w_r_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, w_res};

endmodule
